@@ sv/psr_pkg.sv @@
// Shared types and constants of the two-times pixel resampler.
`default_nettype none

package psr_pkg;

    // Fixed field widths
    localparam int PIX_BITS      = 16;
    localparam int COL_BITS      = 5;
    localparam int SUM_BITS      = 17;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_MODE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH  = 1'd1;

    // Configuration reset values
    localparam logic                ScaleModeReset = 1'b0;
    localparam logic [COL_BITS-1:0] RowWidthReset  = 5'd16;

    // Scale modes
    localparam logic MODE_HALVE  = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // Command kinds handed from front to back
    localparam logic [1:0] CMD_STORE  = 2'd0;  // even row of halve: fill line store
    localparam logic [1:0] CMD_PAIR   = 2'd1;  // odd row, even column: sum left pair
    localparam logic [1:0] CMD_EMIT   = 2'd2;  // odd row, odd column: emit average
    localparam logic [1:0] CMD_DOUBLE = 2'd3;  // double mode: store, emit twice, replay

    typedef struct packed {
        logic [1:0]          kind;
        logic                clr_sum;
        logic [COL_BITS-1:0] col;
        logic [COL_BITS-1:0] last_idx;
        logic                last_col;
        logic                done;
        logic [PIX_BITS-1:0] pix;
    } psr_cmd_t;

endpackage

`default_nettype wire

@@ sv/psr_front.sv @@
// Front end: configuration registers, pixel acceptance and classification into commands.
`default_nettype none

module psr_front #(
    parameter int MAX_WIDTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [psr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [psr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [psr_pkg::PIX_BITS-1:0]       s_tdata,   // [15:0] pixel_value
    input  wire logic [0:0]                         s_tuser,   // [0] frame_start
    input  wire logic                               queue_full,
    output logic                                    push,
    output psr_pkg::psr_cmd_t                       push_cmd
);
    import psr_pkg::*;

    localparam logic [COL_BITS-1:0] MaxWidthL = COL_BITS'(MAX_WIDTH);

    logic                scale_mode_reg;
    logic [COL_BITS-1:0] row_width_reg;
    logic [COL_BITS-1:0] column_count_reg;
    logic [COL_BITS-1:0] column_count_next;
    logic                row_is_odd_reg;
    logic                row_is_odd_next;

    logic [COL_BITS-1:0] width_eff;
    logic [COL_BITS-1:0] last_idx;
    logic [COL_BITS-1:0] col_raw;
    logic [COL_BITS-1:0] col;
    logic                last_col;
    logic                odd_row;
    logic                emit_done;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;
    assign accept    = s_tvalid && s_tready;
    assign push      = accept;

    // Clamp the row width into 1..MAX_WIDTH
    always_comb begin
        if (row_width_reg == '0) begin
            width_eff = COL_BITS'(1);
        end else if (row_width_reg > MaxWidthL) begin
            width_eff = MaxWidthL;
        end else begin
            width_eff = row_width_reg;
        end
    end
    assign last_idx = width_eff - COL_BITS'(1);

    // Position of this pixel; frame start restarts at column 0 of an even row
    assign col_raw   = s_tuser[0] ? '0 : column_count_reg;
    assign odd_row   = s_tuser[0] ? 1'b0 : row_is_odd_reg;
    assign col       = (col_raw > last_idx) ? last_idx : col_raw;
    assign last_col  = (col == last_idx);
    assign emit_done = ({1'b0, col} + (COL_BITS+1)'(1)) >= {1'b0, last_idx};

    // Build the command for the back end
    always_comb begin
        push_cmd.clr_sum  = s_tuser[0];
        push_cmd.col      = col;
        push_cmd.last_idx = last_idx;
        push_cmd.last_col = last_col;
        push_cmd.pix      = s_tdata;
        if (scale_mode_reg == MODE_DOUBLE) begin
            push_cmd.kind = CMD_DOUBLE;
            push_cmd.done = last_col;
        end else if (!odd_row) begin
            push_cmd.kind = CMD_STORE;
            push_cmd.done = 1'b0;
        end else if (!col[0]) begin
            push_cmd.kind = CMD_PAIR;
            push_cmd.done = 1'b0;
        end else begin
            push_cmd.kind = CMD_EMIT;
            push_cmd.done = emit_done;
        end
    end

    // Advance column and row parity
    always_comb begin
        column_count_next = column_count_reg;
        row_is_odd_next   = row_is_odd_reg;
        if (accept) begin
            if (last_col) begin
                column_count_next = '0;
                row_is_odd_next   = !odd_row;
            end else begin
                column_count_next = col + COL_BITS'(1);
                row_is_odd_next   = odd_row;
            end
        end
    end

    // Hold configuration and position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_mode_reg   <= ScaleModeReset;
            row_width_reg    <= RowWidthReset;
            column_count_reg <= '0;
            row_is_odd_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SCALE_MODE: scale_mode_reg <= cfg_data[0];
                    REG_ROW_WIDTH:  row_width_reg  <= cfg_data;
                    default: ;
                endcase
            end
            column_count_reg <= column_count_next;
            row_is_odd_reg   <= row_is_odd_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/psr_queue.sv @@
// Short command queue between the front and back ends.
`default_nettype none

module psr_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire psr_pkg::psr_cmd_t push_cmd,
    output logic             full,
    input  wire logic        pop,
    output logic             not_empty,
    output psr_pkg::psr_cmd_t head_cmd
);
    import psr_pkg::*;

    psr_cmd_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;

    assign full      = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entries_reg[rd_ptr_reg];

    // Track fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_BITS+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_BITS+1)'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    // Hold command payloads
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/psr_back.sv @@
// Back end: line store, pair sum and result sequencer with output register.
`default_nettype none

module psr_back #(
    parameter int MAX_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cmd_valid,
    input  wire psr_pkg::psr_cmd_t              cmd_in,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [psr_pkg::PIX_BITS-1:0]        m_tdata,   // [15:0] out_value
    output logic [0:0]                          m_tuser,   // [0] row_done
    output logic                                m_tlast    // last_of_run
);
    import psr_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HREAD = 3'd1;
    localparam logic [2:0] S_DUP0  = 3'd2;
    localparam logic [2:0] S_DUP1  = 3'd3;
    localparam logic [2:0] S_REP0  = 3'd4;
    localparam logic [2:0] S_REP1  = 3'd5;

    logic [PIX_BITS-1:0] line_store [MAX_WIDTH];
    logic [PIX_BITS-1:0] rd_data_reg;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    psr_cmd_t            cmd_reg;
    logic [SUM_BITS-1:0] pair_sum_reg;
    logic [SUM_BITS-1:0] pair_sum_next;
    logic [COL_BITS-1:0] rep_idx_reg;
    logic [COL_BITS-1:0] rep_idx_next;

    logic                out_valid_reg;
    logic [PIX_BITS-1:0] out_value_reg;
    logic                out_done_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                out_load;
    logic [PIX_BITS-1:0] load_value;
    logic                load_done;
    logic                load_last;

    logic                wr_en;
    logic                rd_en;
    logic [COL_BITS-1:0] rd_addr;
    logic [SUM_BITS:0]   quad_sum;
    logic                rep_end;

    assign out_free = !out_valid_reg || m_tready;
    assign quad_sum = (SUM_BITS+1)'(pair_sum_reg) + (SUM_BITS+1)'(rd_data_reg)
                    + (SUM_BITS+1)'(cmd_reg.pix);
    assign rep_end  = (rep_idx_reg == cmd_reg.last_idx);

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_done_reg;
    assign m_tlast    = out_last_reg;

    // Sequence one command at a time
    always_comb begin
        state_next    = state_reg;
        pair_sum_next = pair_sum_reg;
        rep_idx_next  = rep_idx_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = cmd_in.col;
        out_load      = 1'b0;
        load_value    = cmd_reg.pix;
        load_done     = 1'b0;
        load_last     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    pop = 1'b1;
                    if (cmd_in.clr_sum) begin
                        pair_sum_next = '0;
                    end
                    case (cmd_in.kind)
                        CMD_STORE: begin
                            wr_en = 1'b1;
                        end
                        CMD_PAIR, CMD_EMIT: begin
                            rd_en      = 1'b1;
                            state_next = S_HREAD;
                        end
                        default: begin
                            wr_en      = 1'b1;
                            state_next = S_DUP0;
                        end
                    endcase
                end
            end
            S_HREAD: begin
                if (cmd_reg.kind == CMD_PAIR) begin
                    pair_sum_next = SUM_BITS'(rd_data_reg) + SUM_BITS'(cmd_reg.pix);
                    state_next    = S_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    load_value = quad_sum[SUM_BITS:2];
                    load_done  = cmd_reg.done;
                    load_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUP0: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_DUP1;
                end
            end
            S_DUP1: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    load_done = cmd_reg.last_col;
                    load_last = !cmd_reg.last_col;
                    if (cmd_reg.last_col) begin
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        rep_idx_next = '0;
                        state_next   = S_REP0;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REP0: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    load_value = rd_data_reg;
                    state_next = S_REP1;
                end
            end
            S_REP1: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    load_value = rd_data_reg;
                    load_done  = rep_end;
                    load_last  = rep_end;
                    if (rep_end) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_en        = 1'b1;
                        rd_addr      = rep_idx_reg + COL_BITS'(1);
                        rep_idx_next = rep_idx_reg + COL_BITS'(1);
                        state_next   = S_REP0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and the output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pair_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pair_sum_reg <= pair_sum_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch command, replay index and result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= cmd_in;
        end
        rep_idx_reg <= rep_idx_next;
        if (out_load) begin
            out_value_reg <= load_value;
            out_done_reg  <= load_done;
            out_last_reg  <= load_last;
        end
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store[cmd_in.col[AW-1:0]] <= cmd_in.pix;
        end
        if (rd_en) begin
            rd_data_reg <= line_store[rd_addr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

@@ sv/pixel_stream_two_x_resampler.sv @@
// Top level of the two-times pixel resampler: front end, command queue and back end.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index (0 scale_mode, 1 row_width), data
//  s_       | in        | s_tvalid/s_tready    | tdata pixel_value, tuser frame_start
//  m_       | out       | m_tvalid/m_tready    | tdata out_value, tuser row_done, tlast
//
//  Halve mode in the back end: each even-row pixel is a line-store write and each
//  odd-row pixel is one registered line-store read, then the update or the
//  averaged result. Double mode writes each pixel and emits it twice, and on the
//  last pixel of a row replays the stored row with each pixel twice, one result per
//  cycle from the back-end sequencer while m_tready does not stall it. A four-entry
//  command queue lets the input side run ahead while the output stalls. Reset (aresetn
//  low, synchronous) restores scale_mode 0 and row_width 16; the line store is not cleared.
`default_nettype none

module pixel_stream_two_x_resampler #(
    parameter int MAX_WIDTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [psr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [psr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [psr_pkg::PIX_BITS-1:0]       s_tdata,   // [15:0] pixel_value
    input  wire logic [0:0]                         s_tuser,   // [0] frame_start
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [psr_pkg::PIX_BITS-1:0]            m_tdata,   // [15:0] out_value
    output logic [0:0]                              m_tuser,   // [0] row_done
    output logic                                    m_tlast    // last_of_run
);
    import psr_pkg::*;

    logic     push;
    psr_cmd_t push_cmd;
    logic     queue_full;
    logic     pop;
    logic     not_empty;
    psr_cmd_t head_cmd;

    psr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    psr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    psr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (not_empty),
        .cmd_in    (head_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
